FILE: sv/spl3d_pkg.sv
package spl3d_pkg;

  localparam int MODE_W = 2;
  localparam int NP_W   = 7;
  localparam int IDX_W  = 6;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [NP_W-1:0] NP_RESET = 7'd4;

  // request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  // register select (paddr bit 2)
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_NPTS = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_CATMULL = 2'd0,
    MODE_LINEAR  = 2'd1,
    MODE_BEZIER  = 2'd2
  } interp_mode_e;

endpackage

FILE: sv/spl3d_if.sv
interface spl3d_req_if import spl3d_pkg::*; #(
  parameter int COORD_BITS      = 32,
  parameter int PARAM_FRAC_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [IDX_W-1:0]              point_index;
  logic signed [COORD_BITS-1:0]  load_x;
  logic signed [COORD_BITS-1:0]  load_y;
  logic signed [COORD_BITS-1:0]  load_z;
  logic [PARAM_FRAC_BITS:0]      curve_param;

  modport source (output valid, req_type, point_index, load_x, load_y, load_z, curve_param,
                  input ready);
  modport sink   (input valid, req_type, point_index, load_x, load_y, load_z, curve_param,
                  output ready);
endinterface

interface spl3d_res_if #(
  parameter int COORD_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_BITS-1:0]  out_x;
  logic signed [COORD_BITS-1:0]  out_y;
  logic signed [COORD_BITS-1:0]  out_z;

  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink   (input valid, out_x, out_y, out_z, output ready);
endinterface

FILE: sv/spline3d_point_evaluator.sv
// Pipeline: an evaluate transaction is captured by stage A at acceptance, then passes
//   through B, C, D, E and the output register before its result shows.
// Throughput: one transaction per cycle while the skid slot is empty, loads and evaluates mixed freely.
// Reset: asynchronous, active low; clears valids, sets interp_mode to Catmull-Rom
//   and num_points to 4. The point table is not cleared.
module spline3d_point_evaluator import spl3d_pkg::*; #(
  parameter int MAX_POINTS      = 64,
  parameter int COORD_BITS      = 32,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  spl3d_req_if.sink         req_i,
  spl3d_res_if.source       res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int F  = PARAM_FRAC_BITS;
  localparam int CB = COORD_BITS;
  localparam int TW = F + 1;          // t, v and rounded products (0..S)
  localparam int CW = F + 4;          // signed blend weights, |c| <= ~2S
  localparam int PW = CB + CW;        // weight * coordinate
  localparam int SW = PW + 3;         // four products plus rounding
  localparam int DW = 3 * CB;         // {z, y, x}

  localparam logic [TW-1:0]        S_T   = {1'b1, {F{1'b0}}};
  localparam logic signed [CW-1:0] TWO_S = CW'(S_T) <<< 1;

  // rounded fixed-point product: (a*b + S/2) >> F
  function automatic logic [TW-1:0] qmul(input logic [TW-1:0] a, input logic [TW-1:0] b);
    logic [2*TW-1:0] m;
    m = (2*TW)'(a) * (2*TW)'(b) + ((2*TW)'(1) << (F - 1));
    return m[F +: TW];
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers (APB). Only paddr[2] selects the register.
  // ---------------------------------------------------------------------------
  interp_mode_e    mode_q;
  logic [NP_W-1:0] npts_q;
  logic            cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_CATMULL;
      npts_q <= NP_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_NPTS) begin
        npts_q <= pwdata[NP_W-1:0];
      end else begin
        mode_q <= interp_mode_e'(pwdata[MODE_W-1:0]);
      end
    end
  end

  assign prdata = (paddr[2] == REG_NPTS) ? APB_DW'(npts_q) : APB_DW'(mode_q);

  // last usable index: num_points clamped to 1..MAX_POINTS, minus one
  logic [AW-1:0] nm1;
  always_comb begin
    if (npts_q == '0) begin
      nm1 = '0;
    end else if (int'(npts_q) > MAX_POINTS) begin
      nm1 = AW'(MAX_POINTS - 1);
    end else begin
      nm1 = AW'(npts_q - 1'b1);
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline enable: every stage advances unless the skid slot is occupied.
  // ---------------------------------------------------------------------------
  logic en;
  logic acc;
  logic s_v_q;

  assign en          = !s_v_q;
  assign req_i.ready = en;
  assign acc         = req_i.valid && en;

  // Loads go straight into both table copies at acceptance; an evaluate
  // accepted afterwards reads the table in stage B, so it always sees the write.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;

  assign ram_we    = acc && (req_i.req_type == REQ_LOAD) && (int'(req_i.point_index) < MAX_POINTS);
  assign ram_waddr = AW'(req_i.point_index);
  assign ram_wdata = {req_i.load_z, req_i.load_y, req_i.load_x};

  // ---------------------------------------------------------------------------
  // Stage A: clamp t, scale by (n-1)
  // ---------------------------------------------------------------------------
  logic [TW-1:0]   t_clamp;
  logic            a_v_q;
  logic [AW+F-1:0] a_prod_q;

  assign t_clamp = (req_i.curve_param > S_T) ? S_T : req_i.curve_param;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= acc && (req_i.req_type == REQ_EVAL);
    end
  end

  // (n-1) * t never exceeds (2^AW - 1) * 2^F, so AW+F bits hold it
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_prod_q <= (AW+F)'(nm1) * (AW+F)'(t_clamp);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: segment/fraction split, neighbor indices (table read), squares
  // ---------------------------------------------------------------------------
  logic [AW-1:0] seg;
  logic [F-1:0]  w_a;
  logic [AW:0]   seg_p1, seg_p2;
  logic [AW-1:0] idx0, idx2, idx3;
  logic [TW-1:0] v_a;

  assign seg    = a_prod_q[F +: AW];
  assign w_a    = a_prod_q[F-1:0];
  assign seg_p1 = {1'b0, seg} + (AW+1)'(1);
  assign seg_p2 = {1'b0, seg} + (AW+1)'(2);
  assign idx0   = (seg == '0) ? '0 : seg - 1'b1;
  assign idx2   = (seg_p1 > {1'b0, nm1}) ? nm1 : seg_p1[AW-1:0];
  assign idx3   = (seg_p2 > {1'b0, nm1}) ? nm1 : seg_p2[AW-1:0];
  assign v_a    = S_T - TW'(w_a);

  logic [DW-1:0] rd0, rd1, rd2, rd3;

  spl3d_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_ram_lo (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (en),
    .raddr_a_i (idx0),
    .raddr_b_i (seg),
    .rdata_a_o (rd0),
    .rdata_b_o (rd1)
  );

  spl3d_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_ram_hi (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (en),
    .raddr_a_i (idx2),
    .raddr_b_i (idx3),
    .rdata_a_o (rd2),
    .rdata_b_o (rd3)
  );

  logic          b_v_q;
  logic [TW-1:0] b_w_q, b_w2_q, b_v_val_q, b_v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (en) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_w_q     <= TW'(w_a);
      b_w2_q    <= qmul(TW'(w_a), TW'(w_a));
      b_v_val_q <= v_a;
      b_v2_q    <= qmul(v_a, v_a);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: cubes and mixed terms; capture the four points
  // ---------------------------------------------------------------------------
  logic          c_v_q;
  logic [TW-1:0] c_w_q, c_w2_q, c_w3_q, c_v3_q, c_v2w_q, c_vw2_q;
  logic [DW-1:0] c_p_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (en) begin
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_w_q   <= b_w_q;
      c_w2_q  <= b_w2_q;
      c_w3_q  <= qmul(b_w2_q, b_w_q);
      c_v3_q  <= qmul(b_v2_q, b_v_val_q);
      c_v2w_q <= qmul(b_v2_q, b_w_q);
      c_vw2_q <= qmul(b_v_val_q, b_w2_q);
      c_p_q[0] <= rd0;
      c_p_q[1] <= rd1;
      c_p_q[2] <= rd2;
      c_p_q[3] <= rd3;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage D: blend weights, scaled by 2S
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] w_s, w2_s, w3_s, v3_s, v2w_s, vw2_s;
  logic signed [CW-1:0] coef [4];

  assign w_s   = CW'(c_w_q);
  assign w2_s  = CW'(c_w2_q);
  assign w3_s  = CW'(c_w3_q);
  assign v3_s  = CW'(c_v3_q);
  assign v2w_s = CW'(c_v2w_q);
  assign vw2_s = CW'(c_vw2_q);

  always_comb begin
    unique case (mode_q)
      MODE_LINEAR: begin
        coef[0] = (TWO_S - (w_s <<< 1));
        coef[1] = '0;
        coef[2] = '0;
        coef[3] = w_s <<< 1;
      end
      MODE_BEZIER: begin
        coef[0] = v3_s <<< 1;
        coef[1] = (v2w_s <<< 2) + (v2w_s <<< 1);
        coef[2] = (vw2_s <<< 2) + (vw2_s <<< 1);
        coef[3] = w3_s <<< 1;
      end
      default: begin
        // Catmull-Rom, also for the unused mode code
        coef[0] = -w_s + (w2_s <<< 1) - w3_s;
        coef[1] = TWO_S - ((w2_s <<< 2) + w2_s) + ((w3_s <<< 1) + w3_s);
        coef[2] = w_s + (w2_s <<< 2) - ((w3_s <<< 1) + w3_s);
        coef[3] = w3_s - w2_s;
      end
    endcase
  end

  logic                 d_v_q;
  logic signed [CW-1:0] d_c_q [4];
  logic [DW-1:0]        d_p_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
    end else if (en) begin
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        d_c_q[i] <= coef[i];
        d_p_q[i] <= c_p_q[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage E: twelve weight * coordinate products
  // ---------------------------------------------------------------------------
  logic                 e_v_q;
  logic signed [PW-1:0] e_m_q [3][4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
    end else if (en) begin
      e_v_q <= d_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int i = 0; i < 4; i++) begin
          e_m_q[a][i] <= PW'($signed(d_p_q[i][a*CB +: CB])) * PW'(d_c_q[i]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Final sum, floor((sum + S) / 2S), saturate; feeds the output register
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] acc_sum [3];
  logic signed [SW-1:0] shr     [3];
  logic [CB-1:0]        res_val [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      acc_sum[a] = SW'(e_m_q[a][0]) + SW'(e_m_q[a][1]) + SW'(e_m_q[a][2])
                 + SW'(e_m_q[a][3]) + (SW'(1) <<< F);
      shr[a]     = acc_sum[a] >>> (F + 1);
      if (!(&shr[a][SW-1:CB-1]) && (|shr[a][SW-1:CB-1])) begin
        res_val[a] = shr[a][SW-1] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
      end else begin
        res_val[a] = shr[a][CB-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register plus skid slot: a waiting result never blocks intake of
  // the next transaction; the pipeline halts only while the skid slot is full.
  // ---------------------------------------------------------------------------
  logic          o_v_q;
  logic [DW-1:0] o_d_q, s_d_q;
  logic [DW-1:0] p_data;
  logic          out_free;

  assign p_data   = {res_val[2], res_val[1], res_val[0]};
  assign out_free = res_o.ready || !o_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
      s_v_q <= 1'b0;
    end else if (out_free) begin
      if (s_v_q) begin
        o_v_q <= 1'b1;
        s_v_q <= 1'b0;
      end else begin
        o_v_q <= e_v_q;
      end
    end else if (e_v_q && !s_v_q) begin
      s_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      o_d_q <= s_v_q ? s_d_q : p_data;
    end else if (e_v_q && !s_v_q) begin
      s_d_q <= p_data;
    end
  end

  assign res_o.valid = o_v_q;
  assign res_o.out_x = o_d_q[0*CB +: CB];
  assign res_o.out_y = o_d_q[1*CB +: CB];
  assign res_o.out_z = o_d_q[2*CB +: CB];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_v_q |-> o_v_q)
    else $error("skid slot full while output register empty");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_v_q |=> $stable(e_v_q) && $stable(d_v_q))
    else $error("pipeline moved during stall");

  a_eval_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && a_v_q) |=> b_v_q)
    else $error("evaluate transaction dropped between stages A and B");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && req_i.req_type == REQ_LOAD) |=> !a_v_q)
    else $error("load transaction entered the evaluate pipeline");

endmodule

FILE: sv/spl3d_ram.sv
module spl3d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read-before-write on a same-address collision
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

FILE: test/tb_spline3d_point_evaluator.sv
module tb_spline3d_point_evaluator;
  import spl3d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  NSLOT      = 64;
  localparam int  CW         = 32;
  localparam int  FW         = 16;
  localparam longint ONE     = 64'sd1 << FW;    // t = 1.0
  localparam int  DRAIN_CYC  = 10;              // pipeline depth is 6
  localparam longint LIMIT   = 400000;          // cycle budget for the whole run
  localparam int  HOLD_AT    = 2500;            // cycle where the sink backs off
  localparam int  HOLD_LEN   = 400;
  localparam int  RAND_ITEMS = 1750;

  // one request transaction
  typedef struct {
    bit               kind;
    bit [IDX_W-1:0]   slot;
    bit signed [CW-1:0] px, py, pz;
    bit [FW:0]        t;
  } spl_req_t;

  typedef struct {
    bit signed [CW-1:0] x, y, z;
  } spl_pt_t;

  // Curve predictor plus queue of expected points.
  class curve_scoreboard;
    longint tab_x[NSLOT], tab_y[NSLOT], tab_z[NSLOT];
    bit [NSLOT-1:0] written;
    bit [MODE_W-1:0] mode;
    bit [NP_W-1:0]   npts;
    spl_pt_t pending[$];
    int mismatches, evals, loads, results;

    function new();
      written = '0;
      mode = MODE_CATMULL;
      npts = NP_RESET;
    endfunction

    function longint qmul(longint a, longint b);
      return (a * b + (ONE >>> 1)) >>> FW;
    endfunction

    // floor((sum ci*pi + S) / 2S), then clipped to the coordinate range
    function bit signed [CW-1:0] blend(longint p[4], longint c[4]);
      longint acc, r;
      acc = ONE;
      for (int i = 0; i < 4; i++) acc += c[i] * p[i];
      r = acc >>> (FW + 1);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[CW-1:0];
    endfunction

    function int eff_points();
      int n;
      n = npts;
      if (n < 1) n = 1;
      if (n > NSLOT) n = NSLOT;
      return n;
    endfunction

    function bit eval_safe();
      for (int i = 0; i < eff_points(); i++)
        if (!written[i]) return 0;
      return 1;
    endfunction

    function void note_input(spl_req_t r);
      longint n, t, prod, seg, w, w2, w3, v, v2, v3;
      longint c[4], p[4];
      int ix[4];
      spl_pt_t e;
      if (r.kind == REQ_LOAD) begin
        tab_x[r.slot] = r.px;
        tab_y[r.slot] = r.py;
        tab_z[r.slot] = r.pz;
        written[r.slot] = 1'b1;
        loads++;
        return;
      end
      evals++;
      n = eff_points();
      t = r.t;
      if (t > ONE) t = ONE;
      prod = (n - 1) * t;
      seg = prod >>> FW;
      w = prod & (ONE - 1);
      if (seg > n - 1) seg = n - 1;
      // neighbours clamp at both ends of the table
      ix[0] = int'((seg == 0) ? 0 : seg - 1);
      ix[1] = int'(seg);
      ix[2] = int'((seg + 1 > n - 1) ? n - 1 : seg + 1);
      ix[3] = int'((seg + 2 > n - 1) ? n - 1 : seg + 2);
      w2 = qmul(w, w);
      w3 = qmul(w2, w);
      if (mode == MODE_LINEAR) begin
        c[0] = 2 * (ONE - w); c[1] = 0; c[2] = 0; c[3] = 2 * w;
      end else if (mode == MODE_BEZIER) begin
        v = ONE - w; v2 = qmul(v, v); v3 = qmul(v2, v);
        c[0] = 2 * v3;
        c[1] = 6 * qmul(v2, w);
        c[2] = 6 * qmul(v, w2);
        c[3] = 2 * w3;
      end else begin
        // Catmull-Rom; the unused mode code lands here too
        c[0] = -w + 2 * w2 - w3;
        c[1] = 2 * ONE - 5 * w2 + 3 * w3;
        c[2] = w + 4 * w2 - 3 * w3;
        c[3] = -w2 + w3;
      end
      for (int i = 0; i < 4; i++) p[i] = tab_x[ix[i]];
      e.x = blend(p, c);
      for (int i = 0; i < 4; i++) p[i] = tab_y[ix[i]];
      e.y = blend(p, c);
      for (int i = 0; i < 4; i++) p[i] = tab_z[ix[i]];
      e.z = blend(p, c);
      pending.push_back(e);
    endfunction

    function void check_result(spl_pt_t got);
      spl_pt_t e;
      results++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result x=%0d y=%0d z=%0d", got.x, got.y, got.z);
        return;
      end
      e = pending.pop_front();
      if (e.x !== got.x || e.y !== got.y || e.z !== got.z) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d exp (%0d,%0d,%0d) got (%0d,%0d,%0d)",
                   results, e.x, e.y, e.z, got.x, got.y, got.z);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  spl3d_req_if #(.COORD_BITS(CW), .PARAM_FRAC_BITS(FW)) req ();
  spl3d_res_if #(.COORD_BITS(CW)) res ();

  spline3d_point_evaluator #(
    .MAX_POINTS(NSLOT), .COORD_BITS(CW), .PARAM_FRAC_BITS(FW)
  ) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .req_i(req), .res_o(res),
    .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  curve_scoreboard sb = new();
  longint cycles = 0;
  bit quiet = 0;        // phases with no idling on either side
  bit sink_hold = 0;    // long back-pressure window
  int sink_stall = 0;
  int phases = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    req.valid = 1'b0; req.req_type = REQ_LOAD; req.point_index = '0;
    req.load_x = '0; req.load_y = '0; req.load_z = '0; req.curve_param = '0;
    res.ready = 1'b0;
  end

  // cycle budget
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Sink: random stall after each result transaction, plus the hold window.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sink_stall > 0) begin
        sink_stall--;
        res.ready = 1'b0;
      end else begin
        res.ready = !sink_hold;
      end
    end
  end

  always @(posedge clk_i) begin
    spl_pt_t got;
    if (rst_ni && res.valid && res.ready) begin
      got.x = res.out_x; got.y = res.out_y; got.z = res.out_z;
      sb.check_result(got);
      sink_stall = quiet ? 0 : $urandom_range(0, 11);
    end
  end

  // Long receiver hold-off: the sender keeps offering, so the pipe fills up.
  initial begin
    @(posedge rst_ni);
    repeat (HOLD_AT) @(posedge clk_i);
    sink_hold = 1'b1;
    repeat (HOLD_LEN) @(posedge clk_i);
    sink_hold = 1'b0;
  end

  // APB write: setup cycle, then access cycle; starts and ends at a falling edge.
  task automatic reg_write(bit idx, bit [APB_DW-1:0] val);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (idx == REG_MODE) sb.mode = val[MODE_W-1:0];
    else sb.npts = val[NP_W-1:0];
  endtask

  // One request transaction; entered and left at a falling edge.
  task automatic send_req(spl_req_t r);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req.valid = 1'b1;
    req.req_type = r.kind; req.point_index = r.slot;
    req.load_x = r.px; req.load_y = r.py; req.load_z = r.pz;
    req.curve_param = r.t;
    do @(posedge clk_i); while (!(req.ready));
    sb.note_input(r);
    @(negedge clk_i);
  endtask

  // wait out every expected point, then the pipeline depth
  task automatic drain();
    req.valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYC) @(negedge clk_i);
  endtask

  function automatic bit signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 32'h1FFFFF)) - 32'sh00100000;
      default: return $urandom;
    endcase
  endfunction

  function automatic bit [FW:0] rand_param();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'd65536;
      2: return (FW+1)'($urandom_range(65537, 131071));  // above 1.0
      default: return (FW+1)'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic spl_req_t mk_load(int slot, bit signed [CW-1:0] x, y, z);
    spl_req_t r;
    r.kind = REQ_LOAD; r.slot = IDX_W'(slot); r.px = x; r.py = y; r.pz = z;
    r.t = (FW+1)'($urandom);
    return r;
  endfunction

  function automatic spl_req_t mk_eval(bit [FW:0] t);
    spl_req_t r;
    r.kind = REQ_EVAL; r.slot = IDX_W'($urandom); r.t = t;
    r.px = $urandom; r.py = $urandom; r.pz = $urandom;
    return r;
  endfunction

  // Random request; an evaluate is swapped for a load of the lowest unwritten
  // slot in use, so no unwritten table entry is ever read.
  task automatic send_random();
    spl_req_t r;
    if ($urandom_range(0, 9) < 7) begin
      if (sb.eval_safe()) begin
        r = mk_eval(rand_param());
      end else begin
        for (int i = NSLOT - 1; i >= 0; i--)
          if (!sb.written[i] && i < sb.eff_points()) r.slot = IDX_W'(i);
        r = mk_load(r.slot, rand_coord(), rand_coord(), rand_coord());
      end
    end else begin
      r = mk_load($urandom_range(0, NSLOT - 1), rand_coord(), rand_coord(), rand_coord());
    end
    send_req(r);
  endtask

  // (mode, points) settings; covers all modes incl. the unused code, both ends
  // of num_points, and zero / oversize counts
  typedef struct { bit [MODE_W-1:0] m; bit [NP_W-1:0] n; } phase_cfg_t;
  phase_cfg_t plan[$];

  initial begin
    plan = '{'{MODE_LINEAR, 7'd2}, '{MODE_BEZIER, 7'd3}, '{2'd3, 7'd64},
             '{MODE_CATMULL, 7'd1}, '{MODE_BEZIER, 7'd64}, '{MODE_LINEAR, 7'd64},
             '{MODE_CATMULL, 7'd0}, '{MODE_BEZIER, 7'd5}, '{MODE_CATMULL, 7'd127},
             '{MODE_LINEAR, 7'd1}, '{MODE_CATMULL, 7'd64}, '{MODE_BEZIER, 7'd2}};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset defaults (Catmull-Rom, 4 points), extreme points,
    // t at 0, 1.0 and above 1.0.
    send_req(mk_load(0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh0));
    send_req(mk_load(1, 32'sh80000000, 32'sh7FFFFFFF, -32'sh1));
    send_req(mk_load(2, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh00010000));
    send_req(mk_load(3, 32'sh80000000, 32'sh80000000, 32'shFFFF0000));
    send_req(mk_eval(17'd0));
    send_req(mk_eval(17'd65536));
    send_req(mk_eval(17'd131071));
    send_req(mk_eval(17'd32768));
    send_req(mk_eval(17'd1));
    send_req(mk_eval(17'd65535));
    send_req(mk_eval(17'd21845));
    send_req(mk_load(63, 32'sh12345678, -32'sh12345678, 32'sh0));
    send_req(mk_eval(17'd43690));
    drain();

    foreach (plan[k]) begin
      reg_write(REG_MODE, plan[k].m);
      reg_write(REG_NPTS, plan[k].n);
      quiet = (k % 4 == 3);
      phases++;
      repeat (RAND_ITEMS / plan.size()) send_random();
      drain();
    end

    $display("Covered %0d phases: %0d loads, %0d evaluates, %0d results checked.",
             phases, sb.loads, sb.evals, sb.results);
    $display("Modes 0..3, point counts 0..127, t up to 17-bit max, hold-off of %0d cycles.",
             HOLD_LEN);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d points still expected", sb.mismatches,
               sb.pending.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
